/* design/camera_block_frame_parser_core_macros.svh */
// assertion helpers for the frame parser
`ifndef CAMERA_BLOCK_FRAME_PARSER_CORE_MACROS_SVH
`define CAMERA_BLOCK_FRAME_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CBFP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBFP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CBFP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CBFP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* design/cbfp_pkg.sv */
package cbfp_pkg;

  localparam int BLOCK_WORDS = 6;
  localparam int WIDX_W      = $clog2(BLOCK_WORDS + 1);

  localparam logic [15:0] SYNC_WORD         = 16'haa55;
  localparam logic [15:0] SYNC_WORD_CC      = 16'haa56;
  localparam logic [15:0] SYNC_WORD_SWAPPED = 16'h55aa;
  localparam logic [15:0] PREV_WORD_INIT    = 16'hffff;
  localparam logic [7:0]  SYNC_TIMEOUT_INIT = 8'd50;
  localparam logic [7:0]  COUNT_MAX         = 8'hff;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_CHECKSUM,
    PH_DATA,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SYNC_ZEROS,
    ST_SYNC_TIMEOUT,
    ST_FRAME_DROPPED
  } status_t;

  typedef enum logic {
    KIND_BLOCK,
    KIND_REPORT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] signature;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] blk_width;
    logic [15:0] blk_height;
    logic [15:0] angle_word;
    logic        colour_coded;
    logic        checksum_ok;
    logic [7:0]  good_count;
    status_t     status;
  } result_t;

endpackage

/* design/camera_block_frame_parser_core.sv */
// Camera block frame parser: takes one link byte per cycle (low byte of each word first),
// finds frame sync, checks block checksums and emits one result per block record and per
// frame end or sync fault. A byte goes through an input register and the parser logic
// into a result register, and a new byte is accepted every cycle while the output side
// keeps taking results; while a result waits in the output register the byte in the input
// register is held, whether it makes a result or not, so input stalls once that register
// is full. sync_timeout (reset 50) is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
`include "camera_block_frame_parser_core_macros.svh"

module camera_block_frame_parser_core
  import cbfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [15:0] signature,
  output logic [15:0] x_pos,
  output logic [15:0] y_pos,
  output logic [15:0] blk_width,
  output logic [15:0] blk_height,
  output logic [15:0] angle_word,
  output logic        colour_coded,
  output logic        checksum_ok,
  output logic [7:0]  good_count,
  output logic [1:0]  status
);

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_restart;
  logic       out_load;
  logic       s1_fire;

  // parser state
  logic [7:0]        sync_timeout;
  phase_t            phase, phase_next;
  logic              byte_phase, byte_phase_next;
  logic [7:0]        low_byte_hold, low_byte_hold_next;
  logic              drop_next_byte, drop_next_byte_next;
  logic [15:0]       previous_word, previous_word_next;
  logic [7:0]        search_count, search_count_next;
  logic              block_is_cc, block_is_cc_next;
  logic [15:0]       expected_sum, expected_sum_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [WIDX_W-1:0] word_index, word_index_next;
  logic [7:0]        frame_count, frame_count_next;
  logic              failure_pending, failure_pending_next;
  logic [15:0]       block_words [BLOCK_WORDS];

  logic              bw_write;
  logic              emit;
  logic              emit_rec;
  result_t           res_next;
  result_t           res;

  assign out_load = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte    <= data_byte;
      s1_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_timeout <= SYNC_TIMEOUT_INIT;
    end else if (cfg_wr_en) begin
      sync_timeout <= cfg_wr_data;
    end
  end

  always_comb begin
    logic [15:0]       word;
    logic [15:0]       sum;
    logic [WIDX_W-1:0] wi_inc;
    logic [WIDX_W-1:0] need;
    logic              ok;
    logic [15:0]       rec [BLOCK_WORDS];

    phase_next           = phase;
    byte_phase_next      = byte_phase;
    low_byte_hold_next   = low_byte_hold;
    drop_next_byte_next  = drop_next_byte;
    previous_word_next   = previous_word;
    search_count_next    = search_count;
    block_is_cc_next     = block_is_cc;
    expected_sum_next    = expected_sum;
    running_sum_next     = running_sum;
    word_index_next      = word_index;
    frame_count_next     = frame_count;
    failure_pending_next = failure_pending;
    bw_write             = 1'b0;
    emit                 = 1'b0;
    emit_rec             = 1'b0;
    res_next             = '0;

    word   = {s1_byte, low_byte_hold};
    sum    = running_sum + word;
    wi_inc = word_index + WIDX_W'(1);
    need   = block_is_cc ? WIDX_W'(BLOCK_WORDS) : WIDX_W'(BLOCK_WORDS - 1);
    ok     = (sum == expected_sum);
    // current word overlays the store so the record is complete in this cycle
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      rec[i] = (word_index == WIDX_W'(i)) ? word : block_words[i];
    end

    if (s1_restart) begin
      byte_phase_next      = 1'b0;
      low_byte_hold_next   = '0;
      drop_next_byte_next  = 1'b0;
      block_is_cc_next     = 1'b0;
      expected_sum_next    = '0;
      running_sum_next     = '0;
      word_index_next      = '0;
      failure_pending_next = 1'b0;
      phase_next           = PH_SEARCH;
      previous_word_next   = PREV_WORD_INIT;
      search_count_next    = '0;
      frame_count_next     = '0;
    end else if (drop_next_byte) begin
      drop_next_byte_next = 1'b0;
    end else if (!byte_phase) begin
      low_byte_hold_next = s1_byte;
      byte_phase_next    = 1'b1;
    end else begin
      byte_phase_next = 1'b0;
      unique case (phase)
        PH_SEARCH: begin
          if (word == 16'h0000 && previous_word == 16'h0000) begin
            failure_pending_next = 1'b1;
            emit                 = 1'b1;
            res_next.kind        = KIND_REPORT;
            res_next.status      = ST_SYNC_ZEROS;
            previous_word_next   = PREV_WORD_INIT;
            search_count_next    = '0;
            frame_count_next     = '0;
          end else if (word == SYNC_WORD && previous_word == SYNC_WORD) begin
            block_is_cc_next = 1'b0;
            phase_next       = PH_CHECKSUM;
            frame_count_next = '0;
          end else if (word == SYNC_WORD_CC && previous_word == SYNC_WORD) begin
            block_is_cc_next = 1'b1;
            phase_next       = PH_CHECKSUM;
            frame_count_next = '0;
          end else if (word == SYNC_WORD_SWAPPED) begin
            // byte pairing is off by one, slip a byte
            drop_next_byte_next = 1'b1;
            previous_word_next  = word;
          end else if (search_count >= sync_timeout) begin
            emit               = 1'b1;
            res_next.kind      = KIND_REPORT;
            res_next.status    = ST_SYNC_TIMEOUT;
            previous_word_next = PREV_WORD_INIT;
            search_count_next  = '0;
            frame_count_next   = '0;
          end else begin
            search_count_next  = search_count + 8'd1;
            previous_word_next = word;
          end
        end
        PH_CHECKSUM: begin
          if (word == SYNC_WORD || word == SYNC_WORD_CC) begin
            // start word closes this frame and opens the next without a search
            emit                 = 1'b1;
            res_next.kind        = KIND_REPORT;
            res_next.good_count  = frame_count;
            res_next.status      = failure_pending ? ST_FRAME_DROPPED : ST_OK;
            block_is_cc_next     = (word == SYNC_WORD_CC);
            failure_pending_next = 1'b0;
            phase_next           = PH_CHECKSUM;
            frame_count_next     = '0;
          end else if (word == 16'h0000) begin
            emit                = 1'b1;
            res_next.kind       = KIND_REPORT;
            res_next.good_count = frame_count;
            res_next.status     = ST_OK;
            phase_next          = PH_SEARCH;
            previous_word_next  = PREV_WORD_INIT;
            search_count_next   = '0;
            frame_count_next    = '0;
          end else begin
            expected_sum_next = word;
            running_sum_next  = '0;
            word_index_next   = '0;
            phase_next        = PH_DATA;
          end
        end
        PH_DATA: begin
          bw_write         = (word_index < WIDX_W'(BLOCK_WORDS));
          running_sum_next = sum;
          word_index_next  = wi_inc;
          if (wi_inc >= need) begin
            emit                  = 1'b1;
            emit_rec              = 1'b1;
            res_next.kind         = KIND_BLOCK;
            res_next.signature    = rec[0];
            res_next.x_pos        = rec[1];
            res_next.y_pos        = rec[2];
            res_next.blk_width    = rec[3];
            res_next.blk_height   = rec[4];
            res_next.angle_word   = block_is_cc ? rec[5] : 16'h0000;
            res_next.colour_coded = block_is_cc;
            res_next.checksum_ok  = ok;
            res_next.good_count   = '0;
            res_next.status       = ST_OK;
            if (ok && frame_count != COUNT_MAX) begin
              frame_count_next = frame_count + 8'd1;
            end
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (word == SYNC_WORD) begin
            block_is_cc_next = 1'b0;
            phase_next       = PH_CHECKSUM;
          end else if (word == SYNC_WORD_CC) begin
            block_is_cc_next = 1'b1;
            phase_next       = PH_CHECKSUM;
          end else begin
            failure_pending_next = 1'b0;
            emit                 = 1'b1;
            res_next.kind        = KIND_REPORT;
            res_next.good_count  = frame_count;
            res_next.status      = ST_OK;
            phase_next           = PH_SEARCH;
            previous_word_next   = PREV_WORD_INIT;
            search_count_next    = '0;
            frame_count_next     = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEARCH;
      byte_phase      <= 1'b0;
      low_byte_hold   <= '0;
      drop_next_byte  <= 1'b0;
      previous_word   <= PREV_WORD_INIT;
      search_count    <= '0;
      block_is_cc     <= 1'b0;
      expected_sum    <= '0;
      running_sum     <= '0;
      word_index      <= '0;
      frame_count     <= '0;
      failure_pending <= 1'b0;
    end else if (s1_fire) begin
      phase           <= phase_next;
      byte_phase      <= byte_phase_next;
      low_byte_hold   <= low_byte_hold_next;
      drop_next_byte  <= drop_next_byte_next;
      previous_word   <= previous_word_next;
      search_count    <= search_count_next;
      block_is_cc     <= block_is_cc_next;
      expected_sum    <= expected_sum_next;
      running_sum     <= running_sum_next;
      word_index      <= word_index_next;
      frame_count     <= frame_count_next;
      failure_pending <= failure_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && bw_write) begin
      block_words[word_index] <= {s1_byte, low_byte_hold};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_fire && emit;
    end
    if (s1_fire && emit) begin
      res <= res_next;
    end
  end

  assign kind         = res.kind;
  assign signature    = res.signature;
  assign x_pos        = res.x_pos;
  assign y_pos        = res.y_pos;
  assign blk_width    = res.blk_width;
  assign blk_height   = res.blk_height;
  assign angle_word   = res.angle_word;
  assign colour_coded = res.colour_coded;
  assign checksum_ok  = res.checksum_ok;
  assign good_count   = res.good_count;
  assign status       = res.status;

  `CBFP_ASSERT_IMP(a_search_count_clear, clk, rst, phase == PH_SEARCH, frame_count == 8'd0, "frame count not clear during sync search")
  `CBFP_ASSERT_IMP(a_rec_fields, clk, rst, out_valid && kind == KIND_BLOCK, good_count == 8'd0 && status == ST_OK, "block record carries report fields")
  `CBFP_ASSERT_IMP(a_sync_report, clk, rst, out_valid && kind == KIND_REPORT && (status == ST_SYNC_ZEROS || status == ST_SYNC_TIMEOUT), good_count == 8'd0 && checksum_ok == 1'b0, "sync report with block data")
  `CBFP_ASSERT_NXT(a_rec_to_trailer, clk, rst, s1_fire && emit_rec, phase == PH_TRAILER, "block record not followed by trailer phase")

endmodule
